// ===== src/gmsg_pkg.sv =====
// ----------------------------------------------------------------------------
// gmsg_pkg: shared types and constants for the grid mesh generator
// Field widths, operation codes, item classes and skirt strip codes.
// ----------------------------------------------------------------------------
`default_nettype none

package gmsg_pkg;

  // default build parameters
  localparam int DEF_MAX_GRID        = 256;
  localparam int DEF_COORD_FRAC_BITS = 16;

  // fixed port field widths
  localparam int CFG_W   = 9;
  localparam int ITEM_W  = 18;
  localparam int IDX_W   = 17;
  localparam int COORD_W = 17;

  // grid size register
  localparam logic [CFG_W-1:0] GRID_RESET = CFG_W'(33);
  localparam int               GRID_MIN   = 2;

  // operation codes
  localparam logic OP_VERTEX   = 1'b0;
  localparam logic OP_TRIANGLE = 1'b1;

  // class of a request word
  typedef enum logic [2:0] {
    KIND_OOR,
    KIND_VTX_SURF,
    KIND_VTX_SKIRT,
    KIND_TRI_SURF,
    KIND_TRI_SKIRT
  } kind_t;

  // skirt strips in emission order
  typedef enum logic [1:0] {
    STRIP_BOTTOM,
    STRIP_TOP,
    STRIP_LEFT,
    STRIP_RIGHT
  } strip_t;

endpackage

`default_nettype wire

// ===== src/grid_mesh_with_skirt_generator_unit.sv =====
// ----------------------------------------------------------------------------
// grid_mesh_with_skirt_generator_unit: terrain tile mesh with skirts
// Path: stage 1 to 4 registers, then the output register driving out_valid.
// Throughput: one word per cycle; five register stages, busy is never raised.
// The stage depth is set by the reciprocal multiply and the index multiply.
// Reset: synchronous, clears the pipeline valid bits and loads 33 as the side.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_mesh_with_skirt_generator_unit #(
  parameter int MAX_GRID        = gmsg_pkg::DEF_MAX_GRID,
  parameter int COORD_FRAC_BITS = gmsg_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [gmsg_pkg::ITEM_W-1:0]   in_item_number,
  input  logic                          cfg_wr_en,
  input  logic [gmsg_pkg::CFG_W-1:0]    cfg_wr_data,
  output logic                          out_valid,
  output logic [gmsg_pkg::IDX_W-1:0]    out_index_first,
  output logic [gmsg_pkg::IDX_W-1:0]    out_index_second,
  output logic [gmsg_pkg::IDX_W-1:0]    out_index_third,
  output logic [gmsg_pkg::COORD_W-1:0]  out_coord_x,
  output logic [gmsg_pkg::COORD_W-1:0]  out_coord_y,
  output logic                          out_below_surface,
  output logic                          out_out_of_range
);
  import gmsg_pkg::*;

  // widths derived from the grid limit and the coordinate precision
  localparam int N_W    = $clog2(MAX_GRID + 1);
  localparam int M_W    = $clog2(MAX_GRID);
  localparam int W_CMP  = (2 * N_W + 1 > ITEM_W) ? 2 * N_W + 1 : ITEM_W;
  localparam int REL_W  = N_W + 3;
  localparam int POS_W  = N_W + 1;
  localparam int K_DIV  = ITEM_W + N_W;
  localparam int RD_W   = K_DIV + 1;
  localparam int PROD_W = ITEM_W + RD_W;
  localparam int K_C    = COORD_FRAC_BITS + 2 * M_W;
  localparam int RC_W   = K_C + 1;
  localparam int CP_W   = M_W + RC_W;
  localparam int CX_W   = (COORD_FRAC_BITS + 1 > COORD_W) ? COORD_FRAC_BITS + 1 : COORD_W;
  localparam int MP_W   = ITEM_W + N_W;

  // the receiver cannot stall and every stage advances each cycle
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // reciprocal tables, ceil(2^k / d), built at elaboration
  // --------------------------------------------------------------------------
  logic [RD_W-1:0] rdiv_tab [0:MAX_GRID];
  logic [RC_W-1:0] rc_tab   [0:MAX_GRID-1];

  for (genvar g = 0; g <= MAX_GRID; g++) begin : g_rdiv
    localparam longint DIVISOR = (g == 0) ? 1 : g;
    localparam logic [RD_W-1:0] RVAL = (g == 0) ? '0 :
      RD_W'(((64'd1 << K_DIV) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
    assign rdiv_tab[g] = RVAL;
  end

  for (genvar g = 0; g < MAX_GRID; g++) begin : g_rc
    localparam longint DIVISOR = (g == 0) ? 1 : g;
    localparam logic [RC_W-1:0] RVAL = (g == 0) ? '0 :
      RC_W'(((64'd1 << K_C) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
    assign rc_tab[g] = RVAL;
  end

  // --------------------------------------------------------------------------
  // grid size register and the geometry it implies
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] cfg_src;
  logic [N_W-1:0]   n_eff;
  logic [M_W-1:0]   m_eff;
  logic [W_CMP-1:0] n_w, m_w;

  logic [N_W-1:0]   n_r, n_nxt;
  logic [M_W-1:0]   m_r, m_nxt;
  logic [W_CMP-1:0] np1_r, np1_nxt, n2_r, n2_nxt, n3_r, n3_nxt;
  logic [W_CMP-1:0] nn_r, nn_nxt, nn2n_r, nn2n_nxt, nn4n_r, nn4n_nxt;
  logic [W_CMP-1:0] surf_r, surf_nxt, total_r, total_nxt;
  logic [W_CMP-1:0] m2_r, m2_nxt, m4_r, m4_nxt, m6_r, m6_nxt;
  logic [RD_W-1:0]  rn_r, rn_nxt, rm_r, rm_nxt;
  logic [RC_W-1:0]  rc_r, rc_nxt;

  // clamp the written size and derive counts and reciprocals
  always_comb begin
    cfg_src = rst_n ? cfg_wr_data : GRID_RESET;
    if (32'(cfg_src) < 32'(GRID_MIN)) begin
      n_eff = N_W'(GRID_MIN);
    end else if (32'(cfg_src) > 32'(MAX_GRID)) begin
      n_eff = N_W'(MAX_GRID);
    end else begin
      n_eff = N_W'(cfg_src);
    end
    m_eff     = M_W'(n_eff - N_W'(1));
    n_w       = W_CMP'(n_eff);
    m_w       = W_CMP'(m_eff);
    n_nxt     = n_eff;
    m_nxt     = m_eff;
    np1_nxt   = n_w + W_CMP'(1);
    n2_nxt    = n_w << 1;
    n3_nxt    = (n_w << 1) + n_w;
    nn_nxt    = n_w * n_w;
    nn2n_nxt  = (n_w * n_w) + (n_w << 1);
    nn4n_nxt  = (n_w * n_w) + (n_w << 2);
    surf_nxt  = (m_w * m_w) << 1;
    total_nxt = ((m_w * m_w) << 1) + (m_w << 3);
    m2_nxt    = m_w << 1;
    m4_nxt    = m_w << 2;
    m6_nxt    = (m_w << 2) + (m_w << 1);
    rn_nxt    = rdiv_tab[n_eff];
    rm_nxt    = rdiv_tab[N_W'(m_eff)];
    rc_nxt    = rc_tab[m_eff];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr_en) begin
      n_r     <= n_nxt;
      m_r     <= m_nxt;
      np1_r   <= np1_nxt;
      n2_r    <= n2_nxt;
      n3_r    <= n3_nxt;
      nn_r    <= nn_nxt;
      nn2n_r  <= nn2n_nxt;
      nn4n_r  <= nn4n_nxt;
      surf_r  <= surf_nxt;
      total_r <= total_nxt;
      m2_r    <= m2_nxt;
      m4_r    <= m4_nxt;
      m6_r    <= m6_nxt;
      rn_r    <= rn_nxt;
      rm_r    <= rm_nxt;
      rc_r    <= rc_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: classify the request word
  // --------------------------------------------------------------------------
  logic              s1_valid_r, s1_valid_nxt;
  kind_t             s1_kind_r, s1_kind_nxt;
  logic [ITEM_W-1:0] s1_dvd_r, s1_dvd_nxt;
  logic [REL_W-1:0]  s1_rel_r, s1_rel_nxt;
  logic              s1_lr_r, s1_lr_nxt;
  logic              s1_odd_r, s1_odd_nxt;
  logic [W_CMP-1:0]  item_w, rel_full;

  always_comb begin
    item_w       = W_CMP'(in_item_number);
    s1_valid_nxt = start & ~busy;
    s1_kind_nxt  = KIND_OOR;
    s1_dvd_nxt   = in_item_number;
    s1_lr_nxt    = 1'b0;
    s1_odd_nxt   = in_item_number[0];
    rel_full     = '0;
    if (in_operation == OP_VERTEX) begin
      if (item_w < nn_r) begin
        s1_kind_nxt = KIND_VTX_SURF;
      end else if (item_w < nn4n_r) begin
        s1_kind_nxt = KIND_VTX_SKIRT;
        s1_lr_nxt   = (item_w >= nn2n_r);
        rel_full    = (item_w >= nn2n_r) ? item_w - nn2n_r : item_w - nn_r;
      end
    end else begin
      s1_dvd_nxt = in_item_number >> 1;
      if (item_w >= total_r) begin
        s1_kind_nxt = KIND_OOR;
      end else if (item_w < surf_r) begin
        s1_kind_nxt = KIND_TRI_SURF;
      end else begin
        s1_kind_nxt = KIND_TRI_SKIRT;
        rel_full    = item_w - surf_r;
      end
    end
    s1_rel_nxt = rel_full[REL_W-1:0];
  end

  // --------------------------------------------------------------------------
  // stage 2: reciprocal multiply, strip and offset within the strip
  // --------------------------------------------------------------------------
  logic              s2_valid_r;
  kind_t             s2_kind_r;
  logic [ITEM_W-1:0] s2_dvd_r;
  logic [PROD_W-1:0] s2_prod_r, s2_prod_nxt;
  strip_t            s2_strip_r, s2_strip_nxt;
  logic [POS_W-1:0]  s2_pos_r, s2_pos_nxt;
  logic              s2_odd_r;
  logic [W_CMP-1:0]  rel_w, th1, th2, th3, pos_full;
  logic [RD_W-1:0]   rsel;

  always_comb begin
    rel_w = W_CMP'(s1_rel_r);
    if (s1_kind_r == KIND_TRI_SKIRT) begin
      th1 = m2_r;
      th2 = m4_r;
      th3 = m6_r;
    end else begin
      th1 = W_CMP'(n_r);
      th2 = n2_r;
      th3 = n3_r;
    end
    // triangle strips span 2(n-1) words, vertex strips span n words
    if (rel_w >= th3) begin
      s2_strip_nxt = STRIP_RIGHT;
      pos_full     = rel_w - th3;
    end else if (rel_w >= th2) begin
      s2_strip_nxt = STRIP_LEFT;
      pos_full     = rel_w - th2;
    end else if (rel_w >= th1) begin
      s2_strip_nxt = STRIP_TOP;
      pos_full     = rel_w - th1;
    end else begin
      s2_strip_nxt = STRIP_BOTTOM;
      pos_full     = rel_w;
    end
    if (s1_kind_r == KIND_VTX_SKIRT && s1_lr_r) begin
      s2_strip_nxt = (rel_w >= th1) ? STRIP_RIGHT : STRIP_LEFT;
    end
    s2_pos_nxt  = pos_full[POS_W-1:0];
    rsel        = (s1_kind_r == KIND_TRI_SURF) ? rm_r : rn_r;
    s2_prod_nxt = PROD_W'(s1_dvd_r) * PROD_W'(rsel);
  end

  // --------------------------------------------------------------------------
  // stage 3: quotient and remainder
  // --------------------------------------------------------------------------
  logic              s3_valid_r;
  kind_t             s3_kind_r;
  logic [ITEM_W-1:0] s3_quot_r, s3_quot_nxt;
  logic [M_W-1:0]    s3_rem_r, s3_rem_nxt;
  strip_t            s3_strip_r;
  logic [POS_W-1:0]  s3_pos_r;
  logic              s3_odd_r;
  logic [N_W-1:0]    div_val;
  logic [ITEM_W-1:0] qd, rem_full;

  always_comb begin
    s3_quot_nxt = s2_prod_r[K_DIV +: ITEM_W];
    div_val     = (s2_kind_r == KIND_TRI_SURF) ? N_W'(m_r) : n_r;
    qd          = s3_quot_nxt * ITEM_W'(div_val);
    rem_full    = s2_dvd_r - qd;
    s3_rem_nxt  = rem_full[M_W-1:0];
  end

  // --------------------------------------------------------------------------
  // stage 4: coordinate multiplies and base vertex indices
  // --------------------------------------------------------------------------
  logic              s4_valid_r;
  kind_t             s4_kind_r;
  strip_t            s4_strip_r;
  logic              s4_odd_r, s4_odd_nxt;
  logic [W_CMP-1:0]  s4_v_r, s4_v_nxt, s4_s_r, s4_s_nxt;
  logic [CP_W-1:0]   s4_cx_r, s4_cx_nxt, s4_cy_r, s4_cy_nxt;
  logic [M_W-1:0]    vi, vj, ti, pos_m, add_in;
  logic [ITEM_W-1:0] mul_in;
  logic [MP_W-1:0]   mprod;
  logic [W_CMP-1:0]  s_off;

  always_comb begin
    ti     = s3_pos_r[M_W:1];
    pos_m  = s3_pos_r[M_W-1:0];
    vi     = s3_rem_r;
    vj     = s3_quot_r[M_W-1:0];
    mul_in = s3_quot_r;
    add_in = s3_rem_r;
    s_off  = '0;
    // vertex position inside the grid
    if (s3_kind_r == KIND_VTX_SKIRT) begin
      case (s3_strip_r)
        STRIP_BOTTOM: begin vi = pos_m; vj = '0;   end
        STRIP_TOP:    begin vi = pos_m; vj = m_r;  end
        STRIP_LEFT:   begin vi = '0;    vj = pos_m; end
        STRIP_RIGHT:  begin vi = m_r;   vj = pos_m; end
        default:      begin vi = '0;    vj = '0;   end
      endcase
    end
    // surface vertex v = mul_in * n + add_in, skirt vertex s = n*n + k*n + i
    if (s3_kind_r == KIND_TRI_SKIRT) begin
      case (s3_strip_r)
        STRIP_BOTTOM: begin
          mul_in = '0;
          add_in = ti;
          s_off  = '0;
        end
        STRIP_TOP: begin
          mul_in = ITEM_W'(m_r);
          add_in = ti;
          s_off  = W_CMP'(n_r);
        end
        STRIP_LEFT: begin
          mul_in = ITEM_W'(ti);
          add_in = '0;
          s_off  = n2_r;
        end
        STRIP_RIGHT: begin
          mul_in = ITEM_W'(ti);
          add_in = m_r;
          s_off  = n3_r;
        end
        default: begin
          mul_in = '0;
          add_in = '0;
          s_off  = '0;
        end
      endcase
    end
    mprod      = MP_W'(mul_in) * MP_W'(n_r);
    s4_v_nxt   = W_CMP'(mprod) + W_CMP'(add_in);
    s4_s_nxt   = nn_r + s_off + W_CMP'(ti);
    s4_cx_nxt  = CP_W'(vi) * CP_W'(rc_r);
    s4_cy_nxt  = CP_W'(vj) * CP_W'(rc_r);
    s4_odd_nxt = (s3_kind_r == KIND_TRI_SURF) ? s3_odd_r : s3_pos_r[0];
  end

  // --------------------------------------------------------------------------
  // stage 5: triangle corners, coordinates and flags into the output word
  // --------------------------------------------------------------------------
  logic               out_valid_r;
  logic [IDX_W-1:0]   out_a_r, out_a_nxt, out_b_r, out_b_nxt, out_c_r, out_c_nxt;
  logic [COORD_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic               out_below_r, out_below_nxt, out_oor_r, out_oor_nxt;
  logic [W_CMP-1:0]   v0, v1, vn, vn1, sk0, sk1, ta, tb, tc;
  logic [CX_W-1:0]    cx_full, cy_full;

  always_comb begin
    v0      = s4_v_r;
    v1      = s4_v_r + W_CMP'(1);
    vn      = s4_v_r + W_CMP'(n_r);
    vn1     = s4_v_r + np1_r;
    sk0     = s4_s_r;
    sk1     = s4_s_r + W_CMP'(1);
    cx_full = CX_W'(s4_cx_r >> (2 * M_W));
    cy_full = CX_W'(s4_cy_r >> (2 * M_W));
    ta      = '0;
    tb      = '0;
    tc      = '0;
    // corner order per strip, second triangle of a pair when odd
    if (s4_kind_r == KIND_TRI_SURF) begin
      if (s4_odd_r) begin
        ta = vn; tb = v1; tc = vn1;
      end else begin
        ta = v0; tb = v1; tc = vn;
      end
    end else if (s4_kind_r == KIND_TRI_SKIRT) begin
      case (s4_strip_r)
        STRIP_BOTTOM: begin
          if (s4_odd_r) begin ta = sk0; tb = sk1; tc = v1; end
          else begin ta = v0; tb = sk0; tc = v1; end
        end
        STRIP_TOP: begin
          if (s4_odd_r) begin ta = sk0; tb = v1; tc = sk1; end
          else begin ta = v0; tb = v1; tc = sk0; end
        end
        STRIP_LEFT: begin
          if (s4_odd_r) begin ta = sk0; tb = vn; tc = sk1; end
          else begin ta = v0; tb = vn; tc = sk0; end
        end
        STRIP_RIGHT: begin
          if (s4_odd_r) begin ta = sk0; tb = sk1; tc = vn; end
          else begin ta = v0; tb = sk0; tc = vn; end
        end
        default: begin ta = '0; tb = '0; tc = '0; end
      endcase
    end
    out_a_nxt     = ta[IDX_W-1:0];
    out_b_nxt     = tb[IDX_W-1:0];
    out_c_nxt     = tc[IDX_W-1:0];
    out_x_nxt     = '0;
    out_y_nxt     = '0;
    out_below_nxt = 1'b0;
    out_oor_nxt   = (s4_kind_r == KIND_OOR);
    if (s4_kind_r == KIND_VTX_SURF || s4_kind_r == KIND_VTX_SKIRT) begin
      out_x_nxt     = cx_full[COORD_W-1:0];
      out_y_nxt     = cy_full[COORD_W-1:0];
      out_below_nxt = (s4_kind_r == KIND_VTX_SKIRT);
    end
  end

  // --------------------------------------------------------------------------
  // pipeline registers
  // --------------------------------------------------------------------------
  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    s1_kind_r   <= s1_kind_nxt;
    s1_dvd_r    <= s1_dvd_nxt;
    s1_rel_r    <= s1_rel_nxt;
    s1_lr_r     <= s1_lr_nxt;
    s1_odd_r    <= s1_odd_nxt;

    s2_kind_r   <= s1_kind_r;
    s2_dvd_r    <= s1_dvd_r;
    s2_prod_r   <= s2_prod_nxt;
    s2_strip_r  <= s2_strip_nxt;
    s2_pos_r    <= s2_pos_nxt;
    s2_odd_r    <= s1_odd_r;

    s3_kind_r   <= s2_kind_r;
    s3_quot_r   <= s3_quot_nxt;
    s3_rem_r    <= s3_rem_nxt;
    s3_strip_r  <= s2_strip_r;
    s3_pos_r    <= s2_pos_r;
    s3_odd_r    <= s2_odd_r;

    s4_kind_r   <= s3_kind_r;
    s4_strip_r  <= s3_strip_r;
    s4_odd_r    <= s4_odd_nxt;
    s4_v_r      <= s4_v_nxt;
    s4_s_r      <= s4_s_nxt;
    s4_cx_r     <= s4_cx_nxt;
    s4_cy_r     <= s4_cy_nxt;

    out_a_r     <= out_a_nxt;
    out_b_r     <= out_b_nxt;
    out_c_r     <= out_c_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_below_r <= out_below_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  // output word
  assign out_valid         = out_valid_r;
  assign out_index_first   = out_a_r;
  assign out_index_second  = out_b_r;
  assign out_index_third   = out_c_r;
  assign out_coord_x       = out_x_r;
  assign out_coord_y       = out_y_r;
  assign out_below_surface = out_below_r;
  assign out_out_of_range  = out_oor_r;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for grid_mesh_with_skirt_generator_unit
// Drives vertex and triangle lookups through the start/busy port and predicts
// every answer from the grid size register and the request word. Each strobed
// result is checked field by field against the oldest prediction. Grid sizes,
// including the clamped extremes, are changed between phases once the
// pipeline has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import gmsg_pkg::*;

  localparam int DRAIN_CYCLES = 12;
  localparam int SEGMENTS     = 12;
  localparam int SEG_WORDS    = 70;

  // one entry of the stimulus plan
  typedef enum logic [1:0] {
    STEP_WORD,
    STEP_GRID,
    STEP_HOLD
  } step_kind_t;

  typedef struct {
    step_kind_t        kind;
    logic              op;
    logic [ITEM_W-1:0] item;
    logic [CFG_W-1:0]  grid;
    int                gap_pct;
  } mesh_step_t;

  // one predicted answer
  typedef struct {
    logic [IDX_W-1:0]   idx_first;
    logic [IDX_W-1:0]   idx_second;
    logic [IDX_W-1:0]   idx_third;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               below;
    logic               oor;
  } mesh_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_operation = OP_VERTEX;
  logic [ITEM_W-1:0] in_item_number = '0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic out_valid;
  logic [IDX_W-1:0] out_index_first;
  logic [IDX_W-1:0] out_index_second;
  logic [IDX_W-1:0] out_index_third;
  logic [COORD_W-1:0] out_coord_x;
  logic [COORD_W-1:0] out_coord_y;
  logic out_below_surface;
  logic out_out_of_range;

  mesh_step_t plan_q[$];
  mesh_word_t answer_q[$];
  logic [CFG_W-1:0] grid_reg = GRID_RESET;
  int quiet_cnt = 0;
  int errors = 0;
  int n_vertex_words = 0;
  int n_tri_words = 0;
  int n_past_end = 0;
  int n_grid_writes = 0;

  grid_mesh_with_skirt_generator_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_item_number    (in_item_number),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_index_first   (out_index_first),
    .out_index_second  (out_index_second),
    .out_index_third   (out_index_third),
    .out_coord_x       (out_coord_x),
    .out_coord_y       (out_coord_y),
    .out_below_surface (out_below_surface),
    .out_out_of_range  (out_out_of_range)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // grid size after clamping
  function automatic int eff_grid(input logic [CFG_W-1:0] g);
    if (g < GRID_MIN) return GRID_MIN;
    if (g > DEF_MAX_GRID) return DEF_MAX_GRID;
    return int'(g);
  endfunction

  function automatic int vtx_count(input int n);
    return n * n + 4 * n;
  endfunction

  function automatic int tri_count(input int n);
    return 2 * (n - 1) * (n - 1) + 8 * (n - 1);
  endfunction

  // vertex position or triangle corners for one request
  function automatic mesh_word_t mesh_answer(input logic op, input logic [ITEM_W-1:0] item,
                                             input logic [CFG_W-1:0] grid);
    mesh_word_t w;
    longint unsigned n, m, nn, k, i, j, surf, total, q, base, t, col, v, s;
    strip_t strip;
    logic second;
    w = '{default: '0};
    n = longint'(eff_grid(grid));
    m = n - 1;
    if (op == OP_VERTEX) begin
      nn = n * n;
      i = 0;
      j = 0;
      if (item < nn) begin
        i = item % n;
        j = item / n;
      end else if (item < nn + 2 * n) begin
        // bottom then top skirt row
        k = item - nn;
        i = k % n;
        j = (k / n) * m;
        w.below = 1'b1;
      end else if (item < nn + 4 * n) begin
        // left then right skirt column
        k = item - nn - 2 * n;
        j = k % n;
        i = (k / n) * m;
        w.below = 1'b1;
      end else begin
        w.oor = 1'b1;
      end
      if (!w.oor) begin
        w.x = COORD_W'((i << DEF_COORD_FRAC_BITS) / m);
        w.y = COORD_W'((j << DEF_COORD_FRAC_BITS) / m);
      end
    end else begin
      surf = 2 * m * m;
      total = surf + 8 * m;
      if (item >= total) begin
        w.oor = 1'b1;
      end else if (item < surf) begin
        // two triangles per quad
        q = item >> 1;
        base = (q / m) * n + (q % m);
        if (!item[0]) begin
          w.idx_first  = IDX_W'(base);
          w.idx_second = IDX_W'(base + 1);
          w.idx_third  = IDX_W'(base + n);
        end else begin
          w.idx_first  = IDX_W'(base + n);
          w.idx_second = IDX_W'(base + 1);
          w.idx_third  = IDX_W'(base + n + 1);
        end
      end else begin
        t = item - surf;
        strip = strip_t'(2'(t / (2 * m)));
        col = (t % (2 * m)) >> 1;
        second = t[0];
        case (strip)
          STRIP_BOTTOM: begin
            v = col;
            s = n * n + col;
            if (!second) begin
              w.idx_first = IDX_W'(v); w.idx_second = IDX_W'(s); w.idx_third = IDX_W'(v + 1);
            end else begin
              w.idx_first = IDX_W'(s); w.idx_second = IDX_W'(s + 1); w.idx_third = IDX_W'(v + 1);
            end
          end
          STRIP_TOP: begin
            v = n * m + col;
            s = n * (n + 1) + col;
            if (!second) begin
              w.idx_first = IDX_W'(v); w.idx_second = IDX_W'(v + 1); w.idx_third = IDX_W'(s);
            end else begin
              w.idx_first = IDX_W'(s); w.idx_second = IDX_W'(v + 1); w.idx_third = IDX_W'(s + 1);
            end
          end
          STRIP_LEFT: begin
            v = col * n;
            s = n * (n + 2) + col;
            if (!second) begin
              w.idx_first = IDX_W'(v); w.idx_second = IDX_W'(v + n); w.idx_third = IDX_W'(s);
            end else begin
              w.idx_first = IDX_W'(s); w.idx_second = IDX_W'(v + n); w.idx_third = IDX_W'(s + 1);
            end
          end
          default: begin
            v = m + col * n;
            s = n * (n + 3) + col;
            if (!second) begin
              w.idx_first = IDX_W'(v); w.idx_second = IDX_W'(s); w.idx_third = IDX_W'(v + n);
            end else begin
              w.idx_first = IDX_W'(s); w.idx_second = IDX_W'(s + 1); w.idx_third = IDX_W'(v + n);
            end
          end
        endcase
      end
    end
    return w;
  endfunction

  task automatic queue_word(input logic op, input logic [ITEM_W-1:0] item, input int pct);
    plan_q.push_back('{STEP_WORD, op, item, '0, pct});
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // driver: feeds words and grid writes from the plan queue
  always @(posedge clk) begin : drive_proc
    logic nxt_start;
    logic nxt_op;
    logic [ITEM_W-1:0] nxt_item;
    logic nxt_wr;
    logic [CFG_W-1:0] nxt_wdata;
    mesh_step_t head;
    nxt_start = start;
    nxt_op = in_operation;
    nxt_item = in_item_number;
    nxt_wr = 1'b0;
    nxt_wdata = cfg_wr_data;
    if (!rst_n) begin
      nxt_start = 1'b0;
      quiet_cnt = 0;
      grid_reg = GRID_RESET;
    end else begin
      // word accepted at this edge
      if (start && !busy) begin
        answer_q.push_back(mesh_answer(in_operation, in_item_number, grid_reg));
        if (in_operation == OP_VERTEX) n_vertex_words++;
        else n_tri_words++;
        nxt_start = 1'b0;
      end
      if (answer_q.size() == 0 && !start) quiet_cnt++;
      else quiet_cnt = 0;
      if (!nxt_start && plan_q.size() > 0) begin
        head = plan_q[0];
        case (head.kind)
          STEP_WORD: begin
            if ($urandom_range(99) >= head.gap_pct) begin
              nxt_start = 1'b1;
              nxt_op = head.op;
              nxt_item = head.item;
              void'(plan_q.pop_front());
            end
          end
          STEP_GRID: begin
            // only write once the pipeline has drained
            if (quiet_cnt >= DRAIN_CYCLES) begin
              nxt_wr = 1'b1;
              nxt_wdata = head.grid;
              grid_reg = head.grid;
              n_grid_writes++;
              quiet_cnt = 0;
              void'(plan_q.pop_front());
            end
          end
          default: begin
            if (quiet_cnt >= DRAIN_CYCLES) begin
              quiet_cnt = 0;
              void'(plan_q.pop_front());
            end
          end
        endcase
      end
    end
    start <= nxt_start;
    in_operation <= nxt_op;
    in_item_number <= nxt_item;
    cfg_wr_en <= nxt_wr;
    cfg_wr_data <= nxt_wdata;
  end

  // monitor: compare each strobed result with the oldest prediction
  always @(posedge clk) begin : watch_proc
    mesh_word_t want;
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0) begin
        $display("%0t: result with no prediction pending", $time);
        errors++;
      end else begin
        want = answer_q.pop_front();
        check_field("index_first", want.idx_first, out_index_first);
        check_field("index_second", want.idx_second, out_index_second);
        check_field("index_third", want.idx_third, out_index_third);
        check_field("coord_x", want.x, out_coord_x);
        check_field("coord_y", want.y, out_coord_y);
        check_field("below_surface", want.below, out_below_surface);
        check_field("out_of_range", want.oor, out_out_of_range);
        if (want.oor) n_past_end++;
      end
    end
  end

  // stimulus plan, reset and end of run
  initial begin : fill_proc
    int n, lim, lo, r, pct, surf, m;
    logic op;
    logic [ITEM_W-1:0] item;
    logic [CFG_W-1:0] grid_plan [SEGMENTS];
    grid_plan = '{9'd2, 9'd256, 9'd0, 9'd511, 9'd1, 9'd257, 9'd0, 9'd3, 9'd255, 9'd0,
                  9'd0, 9'd33};
    grid_plan[6] = CFG_W'($urandom_range(200, 4));
    grid_plan[9] = CFG_W'($urandom_range(511));
    grid_plan[10] = CFG_W'($urandom_range(64, 2));

    // directed words at the reset grid size
    n = eff_grid(GRID_RESET);
    m = n - 1;
    surf = 2 * m * m;
    queue_word(OP_VERTEX, '0, 7);
    queue_word(OP_VERTEX, ITEM_W'(n * n - 1), 7);
    queue_word(OP_VERTEX, ITEM_W'(n * n), 7);
    queue_word(OP_VERTEX, ITEM_W'(n * n + 2 * n - 1), 7);
    queue_word(OP_VERTEX, ITEM_W'(n * n + 2 * n), 7);
    queue_word(OP_VERTEX, ITEM_W'(vtx_count(n) - 1), 7);
    queue_word(OP_VERTEX, ITEM_W'(vtx_count(n)), 7);
    queue_word(OP_VERTEX, '1, 7);
    queue_word(OP_TRIANGLE, '0, 7);
    queue_word(OP_TRIANGLE, ITEM_W'(1), 7);
    queue_word(OP_TRIANGLE, ITEM_W'(surf - 1), 7);
    queue_word(OP_TRIANGLE, ITEM_W'(surf), 7);
    queue_word(OP_TRIANGLE, ITEM_W'(surf + 1), 7);
    queue_word(OP_TRIANGLE, ITEM_W'(surf + 2 * m), 7);
    queue_word(OP_TRIANGLE, ITEM_W'(surf + 4 * m + 1), 7);
    queue_word(OP_TRIANGLE, ITEM_W'(surf + 6 * m), 7);
    queue_word(OP_TRIANGLE, ITEM_W'(surf + 6 * m + 1), 7);
    queue_word(OP_TRIANGLE, ITEM_W'(tri_count(n) - 1), 7);
    queue_word(OP_TRIANGLE, ITEM_W'(tri_count(n)), 7);
    queue_word(OP_TRIANGLE, '1, 7);

    // random words over a series of grid sizes
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      pct = (seg < 4) ? 7 : (seg < 8) ? 77 : 0;
      plan_q.push_back('{STEP_GRID, OP_VERTEX, '0, grid_plan[seg], 0});
      n = eff_grid(grid_plan[seg]);
      for (int cnt = 0; cnt < SEG_WORDS; cnt++) begin
        // sender waits for every result now and then
        if (cnt == SEG_WORDS / 2 && seg % 4 == 1)
          plan_q.push_back('{STEP_HOLD, OP_VERTEX, '0, '0, 0});
        op = 1'($urandom_range(1));
        lim = (op == OP_VERTEX) ? vtx_count(n) : tri_count(n);
        lo = (op == OP_VERTEX) ? n * n : 2 * (n - 1) * (n - 1);
        r = $urandom_range(99);
        if (r < 45) item = ITEM_W'($urandom_range(lim - 1));
        else if (r < 80) item = ITEM_W'($urandom_range(lim - 1, lo));
        else if (r < 90) item = ITEM_W'(lim - 2 + $urandom_range(3));
        else item = ITEM_W'($urandom());
        queue_word(op, item, pct);
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (plan_q.size() != 0 || start || answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (answer_q.size() != 0) begin
      $display("%0t: %0d predictions never answered", $time, answer_q.size());
      errors++;
    end
    $display("covered %0d vertex and %0d triangle words, %0d past the end, %0d grid writes",
             n_vertex_words, n_tri_words, n_past_end, n_grid_writes);
    $display("sender gaps of 7, 77 and 0 percent with drains between grid sizes");
    if (errors == 0) begin
      $display("grid_mesh_with_skirt_generator_unit test passed");
    end else begin
      $display("grid_mesh_with_skirt_generator_unit test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("grid_mesh_with_skirt_generator_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire
